// ----- hw/rtl/grid_raycast_column_renderer_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef GRID_RAYCAST_COLUMN_RENDERER_CORE_MACROS_SVH
`define GRID_RAYCAST_COLUMN_RENDERER_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define GRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grc: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define GRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grc: next-cycle check failed");

`endif

// ----- hw/rtl/grc_pkg.sv -----
package grc_pkg;

  // Geometry and sizing
  localparam int MAP_WIDTH   = 16;
  localparam int MAP_HEIGHT  = 16;
  localparam int MAX_ROWS    = 64;
  localparam int RAY_STEP    = 26;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes of the configuration port
  localparam logic [3:0] REG_MAP_0  = 4'd0;
  localparam logic [3:0] REG_MAP_1  = 4'd1;
  localparam logic [3:0] REG_MAP_2  = 4'd2;
  localparam logic [3:0] REG_MAP_3  = 4'd3;
  localparam logic [3:0] REG_COLS   = 4'd4;
  localparam logic [3:0] REG_ROWS   = 4'd5;
  localparam logic [3:0] REG_ANGLE  = 4'd6;
  localparam logic [3:0] REG_DEPTH  = 4'd7;

  // Register reset values
  localparam logic [7:0]  COLS_RST  = 8'd120;
  localparam logic [6:0]  ROWS_RST  = 7'd40;
  localparam logic [15:0] ANGLE_RST = 16'd8192;
  localparam logic [12:0] DEPTH_RST = 13'd4096;

  // Glyph codes
  localparam logic [3:0] GLYPH_SPACE  = 4'd0;
  localparam logic [3:0] GLYPH_FULL   = 4'd1;
  localparam logic [3:0] GLYPH_DARK   = 4'd2;
  localparam logic [3:0] GLYPH_MEDIUM = 4'd3;
  localparam logic [3:0] GLYPH_LIGHT  = 4'd4;
  localparam logic [3:0] GLYPH_HASH   = 4'd5;
  localparam logic [3:0] GLYPH_CROSS  = 4'd6;
  localparam logic [3:0] GLYPH_DOT    = 4'd7;
  localparam logic [3:0] GLYPH_DASH   = 4'd8;

  // cos(0.05 rad) squared in Q0.16
  localparam logic [16:0] COS2_BOUND = 17'd65372;

  // Ray handed from the front end to the marcher
  typedef struct packed {
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [11:0]        px;
    logic [11:0]        py;
  } ray_t;

  // One emitted row
  typedef struct packed {
    logic [5:0] row;
    logic [3:0] glyph;
    logic       last;
  } glyph_t;

  // Quarter-wave sine table, Q1.14
  function automatic logic [14:0] sine_entry(input logic [4:0] idx);
    logic [14:0] v;
    case (idx)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd1606;
      5'd2:    v = 15'd3196;
      5'd3:    v = 15'd4756;
      5'd4:    v = 15'd6270;
      5'd5:    v = 15'd7723;
      5'd6:    v = 15'd9102;
      5'd7:    v = 15'd10394;
      5'd8:    v = 15'd11585;
      5'd9:    v = 15'd12665;
      5'd10:   v = 15'd13623;
      5'd11:   v = 15'd14449;
      5'd12:   v = 15'd15137;
      5'd13:   v = 15'd15679;
      5'd14:   v = 15'd16069;
      5'd15:   v = 15'd16305;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

  // Sine of a binary angle with linear interpolation, Q1.14
  function automatic logic signed [15:0] sine16(input logic [15:0] a);
    logic [14:0] rr;
    logic [4:0]  idx;
    logic [9:0]  frac;
    logic [14:0] base;
    logic [14:0] diff;
    logic [24:0] prod;
    logic [14:0] mag;
    rr   = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    idx  = rr[14:10];
    frac = rr[9:0];
    base = sine_entry(idx);
    diff = 15'd0;
    prod = 25'd0;
    if (idx[4]) begin
      mag = 15'd16384;
    end else begin
      diff = sine_entry(idx + 5'd1) - base;
      prod = {10'd0, diff} * {15'd0, frac} + 25'd512;
      mag  = base + prod[24:10];
    end
    return a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// ----- hw/rtl/grc_fifo.sv -----
module grc_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/grc_front.sv -----
module grc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_push_i,
  output logic          item_full_o,
  input  logic [7:0]    column_i,
  input  logic [11:0]   player_x_i,
  input  logic [11:0]   player_y_i,
  input  logic [15:0]   player_heading_i,
  input  logic [7:0]    cols_i,
  input  logic [15:0]   view_angle_i,
  output logic          ray_push_o,
  input  logic          ray_full_i,
  output grc_pkg::ray_t ray_o
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_SIN  = 5'b00100,
    F_COS  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  fstate_e            state_q, state_d;
  logic [23:0]        num_q, num_d;
  logic [8:0]         rem_q, rem_d;
  logic [7:0]         den_q, den_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [15:0]        head_q, head_d;
  logic [15:0]        angle_q, angle_d;
  logic [11:0]        px_q, px_d, py_q, py_d;
  logic signed [15:0] ex_q, ex_d, ey_q, ey_d;
  logic [8:0]         rem_sh;
  logic               ge;
  logic signed [15:0] trig;

  assign item_full_o = (state_q != F_IDLE);
  assign ray_push_o  = (state_q == F_PUSH);
  assign ray_o       = '{ex: ex_q, ey: ey_q, px: px_q, py: py_q};

  // One quotient bit per cycle of column * fov / columns
  assign rem_sh = {rem_q[7:0], num_q[23]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  // Shared sine lookup: sine first, then cosine as a quarter turn ahead
  assign trig = grc_pkg::sine16((state_q == F_SIN) ? angle_q : angle_q + 16'd16384);

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    head_d  = head_q;
    angle_d = angle_q;
    px_d    = px_q;
    py_d    = py_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    case (state_q)
      F_IDLE: begin
        if (item_push_i) begin
          num_d   = {16'd0, column_i} * {8'd0, view_angle_i};
          den_d   = (cols_i == 8'd0) ? 8'd1 : cols_i;
          rem_d   = 9'd0;
          cnt_d   = 5'd23;
          head_d  = player_heading_i;
          px_d    = player_x_i;
          py_d    = player_y_i;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d = ge ? rem_sh - {1'b0, den_q} : rem_sh;
        num_d = {num_q[22:0], ge};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          angle_d = head_q - {1'b0, view_angle_i[15:1]} + num_d[15:0];
          state_d = F_SIN;
        end
      end
      F_SIN: begin
        ex_d    = trig;
        state_d = F_COS;
      end
      F_COS: begin
        ey_d    = trig;
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!ray_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold working values
  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    cnt_q   <= cnt_d;
    head_q  <= head_d;
    angle_q <= angle_d;
    px_q    <= px_d;
    py_q    <= py_d;
    ex_q    <= ex_d;
    ey_q    <= ey_d;
  end

endmodule

// ----- hw/rtl/grc_back.sv -----
module grc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  grc_pkg::ray_t    ray_i,
  input  logic             ray_empty_i,
  output logic             ray_pop_o,
  input  logic [3:0][63:0] map_i,
  input  logic [6:0]       rows_i,
  input  logic [12:0]      depth_i,
  output grc_pkg::glyph_t  out_o,
  output logic             out_push_o,
  input  logic             out_full_i
);

  typedef enum logic [11:0] {
    B_IDLE  = 12'b000000000001,
    B_STEP  = 12'b000000000010,
    B_VEC   = 12'b000000000100,
    B_MUL   = 12'b000000001000,
    B_SUM   = 12'b000000010000,
    B_SQR   = 12'b000000100000,
    B_CMP   = 12'b000001000000,
    B_SEL   = 12'b000010000000,
    B_CEIL  = 12'b000100000000,
    B_DIV   = 12'b001000000000,
    B_SHADE = 12'b010000000000,
    B_EMIT  = 12'b100000000000
  } bstate_e;

  localparam logic signed [8:0] StepS = 9'(grc_pkg::RAY_STEP);

  bstate_e            state_q, state_d;
  logic signed [15:0] ex_q, ex_d, ey_q, ey_d;
  logic [11:0]        px_q, px_d, py_q, py_d;
  logic signed [31:0] posx_q, posx_d, posy_q, posy_d;
  logic [13:0]        dist_q, dist_d;
  logic [3:0]         cx_q, cx_d, cy_q, cy_d;
  logic [1:0]         k_q, k_d;
  logic signed [13:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [29:0] p1_q, p1_d, p2_q, p2_d;
  logic signed [27:0] s1_q, s1_d, s2_q, s2_d;
  logic signed [30:0] n_q, n_d;
  logic [25:0]        sq_q, sq_d;
  logic signed [61:0] nn_q, nn_d;
  logic [42:0]        bnd_q, bnd_d;
  logic               npos_q, npos_d, sqnz_q, sqnz_d;
  logic [3:0]         near_q, near_d;
  logic [25:0]        sqa_q [4];
  logic [25:0]        sqa_d [4];
  logic               bnd_hit_q, bnd_hit_d;
  logic [6:0]         h_q, h_d;
  logic [20:0]        mag_q, mag_d;
  logic [14:0]        den_q, den_d;
  logic [15:0]        rem_q, rem_d;
  logic [4:0]         dcnt_q, dcnt_d;
  logic               neg_q, neg_d;
  logic signed [7:0]  ceil_q, ceil_d, floor_q, floor_d;
  logic [3:0]         shade_q, shade_d;
  logic [5:0]         y_q, y_d;

  logic signed [24:0] stepx, stepy;
  logic signed [31:0] nposx, nposy;
  logic               inx, iny, wall;
  logic [3:0]         ncx, ncy;
  logic [63:0]        word;
  logic [4:0]         cxk, cyk;
  logic [1:0]         a_idx, b_idx;
  logic               b_set;
  logic signed [14:0] dm;
  logic signed [21:0] num, num_abs;
  logic [15:0]        rem_sh;
  logic               ge;
  logic [15:0]        dist4, dist3;
  logic signed [7:0]  ys;
  logic [6:0]         rr;
  logic [8:0]         h3;
  logic [9:0]         h9;
  logic [10:0]        r20;
  logic [3:0]         glyph;

  // Next ray point and its map cell
  assign stepx = ex_q * StepS;
  assign stepy = ey_q * StepS;
  assign nposx = posx_q + {{7{stepx[24]}}, stepx};
  assign nposy = posy_q + {{7{stepy[24]}}, stepy};
  assign inx   = nposx[31] ? (&nposx[31:22] && |nposx[21:0])
                           : (nposx[31:22] < 10'(grc_pkg::MAP_WIDTH));
  assign iny   = nposy[31] ? (&nposy[31:22] && |nposy[21:0])
                           : (nposy[31:22] < 10'(grc_pkg::MAP_HEIGHT));
  assign ncx   = nposx[31] ? 4'd0 : nposx[25:22];
  assign ncy   = nposy[31] ? 4'd0 : nposy[25:22];
  assign word  = map_i[ncy[3:2]];
  assign wall  = word[{ncy[1:0], ncx}];

  // Corner of the hit cell for the current corner index
  assign cxk = {1'b0, cx_q} + {4'd0, k_q[1]};
  assign cyk = {1'b0, cy_q} + {4'd0, k_q[0]};

  // Pick the two nearest corners, earlier corner wins ties
  always_comb begin
    a_idx = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (sqa_q[i] < sqa_q[a_idx]) a_idx = 2'(i);
    end
    b_idx = 2'd0;
    b_set = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) != a_idx && (!b_set || sqa_q[i] < sqa_q[b_idx])) begin
        b_idx = 2'(i);
        b_set = 1'b1;
      end
    end
  end

  // Ceiling numerator and one quotient bit per cycle
  assign dm      = $signed({1'b0, dist_q}) - 15'sd512;
  assign num     = $signed({1'b0, h_q}) * dm;
  assign num_abs = num[21] ? -num : num;
  assign rem_sh  = {rem_q[14:0], mag_q[20]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign dist4   = {dist_q, 2'b00};
  assign dist3   = {2'b00, dist_q} + {1'b0, dist_q, 1'b0};

  // Glyph of the current row
  assign ys  = $signed({2'b00, y_q});
  assign rr  = h_q - {1'b0, y_q};
  assign h3  = {1'b0, h_q, 1'b0} + {2'b00, h_q};
  assign h9  = {h_q, 3'b000} + {3'b000, h_q};
  assign r20 = {rr, 4'b0000} + {2'b00, rr, 2'b00};
  always_comb begin
    if (ys < ceil_q) begin
      glyph = grc_pkg::GLYPH_SPACE;
    end else if (ys > ceil_q && ys <= floor_q) begin
      glyph = shade_q;
    end else if ({rr, 3'b000} <= {3'b000, h_q}) begin
      glyph = grc_pkg::GLYPH_HASH;
    end else if ({1'b0, rr, 2'b00} < {3'b000, h_q}) begin
      glyph = grc_pkg::GLYPH_CROSS;
    end else if ({rr, 3'b000} < {1'b0, h3}) begin
      glyph = grc_pkg::GLYPH_DOT;
    end else if (r20 < {1'b0, h9}) begin
      glyph = grc_pkg::GLYPH_DASH;
    end else begin
      glyph = grc_pkg::GLYPH_SPACE;
    end
  end

  assign ray_pop_o  = (state_q == B_IDLE) && !ray_empty_i;
  assign out_push_o = (state_q == B_EMIT);
  assign out_o      = '{row: y_q, glyph: glyph, last: ({1'b0, y_q} == h_q - 7'd1)};

  always_comb begin
    state_d   = state_q;
    ex_d      = ex_q;
    ey_d      = ey_q;
    px_d      = px_q;
    py_d      = py_q;
    posx_d    = posx_q;
    posy_d    = posy_q;
    dist_d    = dist_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    k_d       = k_q;
    vx_d      = vx_q;
    vy_d      = vy_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    s1_d      = s1_q;
    s2_d      = s2_q;
    n_d       = n_q;
    sq_d      = sq_q;
    nn_d      = nn_q;
    bnd_d     = bnd_q;
    npos_d    = npos_q;
    sqnz_d    = sqnz_q;
    near_d    = near_q;
    sqa_d     = sqa_q;
    bnd_hit_d = bnd_hit_q;
    h_d       = h_q;
    mag_d     = mag_q;
    den_d     = den_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    neg_d     = neg_q;
    ceil_d    = ceil_q;
    floor_d   = floor_q;
    shade_d   = shade_q;
    y_d       = y_q;
    case (state_q)
      B_IDLE: begin
        if (!ray_empty_i) begin
          ex_d      = ray_i.ex;
          ey_d      = ray_i.ey;
          px_d      = ray_i.px;
          py_d      = ray_i.py;
          posx_d    = {6'd0, ray_i.px, 14'd0};
          posy_d    = {6'd0, ray_i.py, 14'd0};
          dist_d    = 14'd0;
          bnd_hit_d = 1'b0;
          h_d       = (rows_i > 7'(grc_pkg::MAX_ROWS)) ? 7'(grc_pkg::MAX_ROWS) : rows_i;
          state_d   = B_STEP;
        end
      end
      // March one step; stop on leaving the map, a wall or the depth
      B_STEP: begin
        if (dist_q < {1'b0, depth_i}) begin
          dist_d = dist_q + 14'(grc_pkg::RAY_STEP);
          posx_d = nposx;
          posy_d = nposy;
          if (!inx || !iny) begin
            dist_d  = {1'b0, depth_i};
            state_d = B_CEIL;
          end else if (wall) begin
            cx_d    = ncx;
            cy_d    = ncy;
            k_d     = 2'd0;
            state_d = B_VEC;
          end
        end else begin
          state_d = B_CEIL;
        end
      end
      B_VEC: begin
        vx_d    = $signed({1'b0, cxk, 8'd0}) - $signed({2'b00, px_q});
        vy_d    = $signed({1'b0, cyk, 8'd0}) - $signed({2'b00, py_q});
        state_d = B_MUL;
      end
      B_MUL: begin
        p1_d    = ex_q * vx_q;
        p2_d    = ey_q * vy_q;
        s1_d    = vx_q * vx_q;
        s2_d    = vy_q * vy_q;
        state_d = B_SUM;
      end
      B_SUM: begin
        n_d     = {p1_q[29], p1_q} + {p2_q[29], p2_q};
        sq_d    = {1'b0, s1_q[24:0]} + {1'b0, s2_q[24:0]};
        state_d = B_SQR;
      end
      B_SQR: begin
        nn_d    = n_q * n_q;
        bnd_d   = {26'd0, grc_pkg::COS2_BOUND} * {17'd0, sq_q};
        npos_d  = !n_q[30] && (n_q != 31'sd0);
        sqnz_d  = (sq_q != 26'd0);
        state_d = B_CMP;
      end
      // Record whether the corner lies within the boundary cone
      B_CMP: begin
        near_d[k_q] = sqnz_q && npos_q && ($unsigned(nn_q) > {7'd0, bnd_q, 12'd0});
        sqa_d[k_q]  = sq_q;
        k_d         = k_q + 2'd1;
        state_d     = (k_q == 2'd3) ? B_SEL : B_VEC;
      end
      B_SEL: begin
        bnd_hit_d = near_q[a_idx] || near_q[b_idx];
        state_d   = B_CEIL;
      end
      B_CEIL: begin
        if (dist_q == 14'd0) begin
          ceil_d  = -8'sd1;
          state_d = B_SHADE;
        end else begin
          neg_d   = num[21];
          mag_d   = num_abs[20:0];
          den_d   = {dist_q, 1'b0};
          rem_d   = 16'd0;
          dcnt_d  = 5'd20;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
        mag_d  = {mag_q[19:0], ge};
        dcnt_d = dcnt_q - 5'd1;
        if (dcnt_q == 5'd0) begin
          if (neg_q) begin
            ceil_d = (mag_d != 21'd0) ? -8'sd1 : 8'sd0;
          end else begin
            ceil_d = $signed({1'b0, mag_d[6:0]});
          end
          state_d = B_SHADE;
        end
      end
      // Set the floor row and pick the wall shade by distance; a boundary hit shows blank
      B_SHADE: begin
        floor_d = $signed({1'b0, h_q}) - ceil_q;
        if (bnd_hit_q) begin
          shade_d = grc_pkg::GLYPH_SPACE;
        end else if (dist4 <= {3'd0, depth_i}) begin
          shade_d = grc_pkg::GLYPH_FULL;
        end else if (dist3 < {3'd0, depth_i}) begin
          shade_d = grc_pkg::GLYPH_DARK;
        end else if ({1'b0, dist_q, 1'b0} < {3'd0, depth_i}) begin
          shade_d = grc_pkg::GLYPH_MEDIUM;
        end else if (dist_q < {1'b0, depth_i}) begin
          shade_d = grc_pkg::GLYPH_LIGHT;
        end else begin
          shade_d = grc_pkg::GLYPH_SPACE;
        end
        y_d     = 6'd0;
        state_d = (h_q == 7'd0) ? B_IDLE : B_EMIT;
      end
      B_EMIT: begin
        if (!out_full_i) begin
          y_d = y_q + 6'd1;
          if ({1'b0, y_q} == h_q - 7'd1) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold working values
  always_ff @(posedge clk_i) begin
    ex_q      <= ex_d;
    ey_q      <= ey_d;
    px_q      <= px_d;
    py_q      <= py_d;
    posx_q    <= posx_d;
    posy_q    <= posy_d;
    dist_q    <= dist_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    k_q       <= k_d;
    vx_q      <= vx_d;
    vy_q      <= vy_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    n_q       <= n_d;
    sq_q      <= sq_d;
    nn_q      <= nn_d;
    bnd_q     <= bnd_d;
    npos_q    <= npos_d;
    sqnz_q    <= sqnz_d;
    near_q    <= near_d;
    sqa_q     <= sqa_d;
    bnd_hit_q <= bnd_hit_d;
    h_q       <= h_d;
    mag_q     <= mag_d;
    den_q     <= den_d;
    rem_q     <= rem_d;
    dcnt_q    <= dcnt_d;
    neg_q     <= neg_d;
    ceil_q    <= ceil_d;
    floor_q   <= floor_d;
    shade_q   <= shade_d;
    y_q       <= y_d;
  end

endmodule

// ----- hw/rtl/grid_raycast_column_renderer_core.sv -----
// Front end: angle divider, sine, cosine, hand-off; it takes a new column only once idle.
// Marcher: one ray step per cycle (up to view_depth/26 + 1 steps), then the corner
// test on a wall hit (vector, multiply, sum, square, compare per corner, then select),
// the ceiling divider and the shade, then one emitted row per cycle while the result
// queue is not full. Throughput is set by the marcher.
// Reset is asynchronous, active low: queues empty, map clear, registers at defaults.
module grid_raycast_column_renderer_core #(
  parameter int QUEUE_DEPTH = grc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  column_i,
  input  logic [11:0] player_x_i,
  input  logic [11:0] player_y_i,
  input  logic [15:0] player_heading_i,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  row_o,
  output logic [3:0]  glyph_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int RayW   = $bits(grc_pkg::ray_t);
  localparam int GlyphW = $bits(grc_pkg::glyph_t);

  logic [3:0][63:0] map_q;
  logic [7:0]       cols_q;
  logic [6:0]       rows_q;
  logic [15:0]      angle_q;
  logic [12:0]      depth_q;

  grc_pkg::ray_t    ray_in, ray_out;
  grc_pkg::glyph_t  res_in, res_out;
  logic             ray_push, ray_full, ray_pop, ray_empty;
  logic             res_push, res_full;

  assign cfg_ready_o = 1'b1;

  // Apply configuration requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      cols_q  <= grc_pkg::COLS_RST;
      rows_q  <= grc_pkg::ROWS_RST;
      angle_q <= grc_pkg::ANGLE_RST;
      depth_q <= grc_pkg::DEPTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        grc_pkg::REG_MAP_0: map_q[0] <= cfg_data_i;
        grc_pkg::REG_MAP_1: map_q[1] <= cfg_data_i;
        grc_pkg::REG_MAP_2: map_q[2] <= cfg_data_i;
        grc_pkg::REG_MAP_3: map_q[3] <= cfg_data_i;
        grc_pkg::REG_COLS:  cols_q   <= cfg_data_i[7:0];
        grc_pkg::REG_ROWS:  rows_q   <= cfg_data_i[6:0];
        grc_pkg::REG_ANGLE: angle_q  <= cfg_data_i[15:0];
        grc_pkg::REG_DEPTH: depth_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  grc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_push_i      (push),
    .item_full_o      (full),
    .column_i         (column_i),
    .player_x_i       (player_x_i),
    .player_y_i       (player_y_i),
    .player_heading_i (player_heading_i),
    .cols_i           (cols_q),
    .view_angle_i     (angle_q),
    .ray_push_o       (ray_push),
    .ray_full_i       (ray_full),
    .ray_o            (ray_in)
  );

  grc_fifo #(
    .DATA_W (RayW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_ray_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ray_push),
    .full_o  (ray_full),
    .data_i  (ray_in),
    .pop_i   (ray_pop),
    .empty_o (ray_empty),
    .data_o  (ray_out)
  );

  grc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ray_i       (ray_out),
    .ray_empty_i (ray_empty),
    .ray_pop_o   (ray_pop),
    .map_i       (map_q),
    .rows_i      (rows_q),
    .depth_i     (depth_q),
    .out_o       (res_in),
    .out_push_o  (res_push),
    .out_full_i  (res_full)
  );

  grc_fifo #(
    .DATA_W (GlyphW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign row_o   = res_out.row;
  assign glyph_o = res_out.glyph;
  assign last_o  = res_out.last;

endmodule

// ----- hw/rtl/grc_checker.sv -----
`include "grid_raycast_column_renderer_core_macros.svh"

module grc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [5:0] row_o,
  input logic [3:0] glyph_o,
  input logic       last_o
);

  // Glyph codes stay within the defined set
  `GRC_ASSERT_NOW(a_glyph_range, !empty, glyph_o <= grc_pkg::GLYPH_DASH)

  // Rows of one column come out in order
  `GRC_ASSERT_NEXT(a_row_advance, pop && !empty && !last_o, empty || row_o == $past(row_o) + 6'd1)

  // A new column starts at row zero
  `GRC_ASSERT_NEXT(a_column_restart, pop && !empty && last_o, empty || row_o == 6'd0)

  // A waiting result holds until taken
  `GRC_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(row_o) && $stable(glyph_o) && $stable(last_o))

endmodule

bind grid_raycast_column_renderer_core grc_checker u_grc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .empty   (empty),
  .pop     (pop),
  .row_o   (row_o),
  .glyph_o (glyph_o),
  .last_o  (last_o)
);
